// ----- hdl/mkd_pkg.sv -----
// Package for the Morse key decoder: event codes, register indexes, the
// configuration and result types, and the letter lookup function.
// Depends on nothing; every other file of the block but mkd_key_if imports it.
package mkd_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GLITCH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOT    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DASH   = 4'd3;

    localparam logic [CFG_W-1:0] GLITCH_RST = 16'd25;
    localparam logic [CFG_W-1:0] SHORT_RST  = 16'd200;
    localparam logic [CFG_W-1:0] DOT_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] DASH_RST   = 16'd2000;

    localparam logic [2:0] SYM_MAX      = 3'd4;
    localparam logic [2:0] SYM_OVERLONG = 3'd5;
    localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;

    typedef enum logic [1:0] {
        EV_DOT  = 2'd0,
        EV_DASH = 2'd1,
        EV_END  = 2'd2
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] glitch_ms;
        logic [CFG_W-1:0] short_limit;
        logic [CFG_W-1:0] dot_limit;
        logic [CFG_W-1:0] dash_limit;
    } t_cfg;

    typedef struct packed {
        t_event     event_res;
        logic [6:0] letter;
        logic       letter_valid;
    } t_result;

    // Symbols are stored first at bit 0, a dash as one.
    function automatic logic [6:0] decode_letter(input logic [2:0] count,
                                                 input logic [3:0] bits);
        logic [7:0] c;
        c = 8'h3F;
        unique case (count)
            3'd1: c = bits[0] ? "T" : "E";
            3'd2: begin
                unique case (bits[1:0])
                    2'd0:    c = "I";
                    2'd1:    c = "N";
                    2'd2:    c = "A";
                    default: c = "M";
                endcase
            end
            3'd3: begin
                unique case (bits[2:0])
                    3'd0:    c = "S";
                    3'd1:    c = "D";
                    3'd2:    c = "R";
                    3'd3:    c = "G";
                    3'd4:    c = "U";
                    3'd5:    c = "K";
                    3'd6:    c = "W";
                    default: c = "O";
                endcase
            end
            3'd4: begin
                unique case (bits)
                    4'd0:    c = "H";
                    4'd1:    c = "B";
                    4'd2:    c = "L";
                    4'd3:    c = "Z";
                    4'd4:    c = "F";
                    4'd5:    c = "C";
                    4'd6:    c = "P";
                    4'd8:    c = "V";
                    4'd9:    c = "X";
                    4'd11:   c = "Q";
                    4'd13:   c = "Y";
                    4'd14:   c = "J";
                    default: c = "?";
                endcase
            end
            default: c = "?";
        endcase
        return c[6:0];
    endfunction

endpackage

// ----- hdl/mkd_key_if.sv -----
// Input channel of the Morse key decoder: one sampled key level per word.
// Depends on no other file; valid/ready handshake.
interface mkd_key_if;
    logic valid;
    logic ready;
    logic key_level;

    modport source (output valid, output key_level, input ready);
    modport sink   (input valid, input key_level, output ready);
endinterface

// ----- hdl/mkd_res_if.sv -----
// Output channel of the Morse key decoder: one decode event per word.
// Imports mkd_pkg, but the event field is a plain two-bit vector; valid/ready handshake.
interface mkd_res_if;
    import mkd_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [6:0] letter;
    logic       letter_valid;

    modport source (output valid, output event_res, output letter, output letter_valid,
                    input ready);
    modport sink   (input valid, input event_res, input letter, input letter_valid,
                    output ready);
endinterface

// ----- hdl/mkd_cfg.sv -----
// Configuration register file of the Morse key decoder: four timing bounds.
// Depends on mkd_pkg for the register indexes, reset values and t_cfg.
module mkd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mkd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mkd_pkg::CFG_W-1:0]     i_cfg_data,
    output mkd_pkg::t_cfg                 o_cfg
);
    import mkd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GLITCH: n_cfg.glitch_ms   = i_cfg_data;
                REG_SHORT:  n_cfg.short_limit = i_cfg_data;
                REG_DOT:    n_cfg.dot_limit   = i_cfg_data;
                REG_DASH:   n_cfg.dash_limit  = i_cfg_data;
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glitch_ms   <= GLITCH_RST;
            r_cfg.short_limit <= SHORT_RST;
            r_cfg.dot_limit   <= DOT_RST;
            r_cfg.dash_limit  <= DASH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ----- hdl/mkd_core.sv -----
// Per-tick decode logic: edge detection, saturating press timer, press
// classification and the dot/dash store. Depends on mkd_pkg.
module mkd_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_key_level,
    input  mkd_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output mkd_pkg::t_result o_res
);
    import mkd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    logic                  r_prev;
    logic [COUNT_BITS-1:0] r_elapsed;
    logic [3:0]            r_bits;
    logic [2:0]            r_count;

    logic                  n_prev;
    logic [COUNT_BITS-1:0] n_elapsed;
    logic [3:0]            n_bits;
    logic [2:0]            n_count;

    logic                  fall;
    logic                  rise;
    logic [COUNT_BITS-1:0] inc;
    logic [CMP_W-1:0]      len;
    logic [CMP_W-1:0]      lim_glitch;
    logic [CMP_W-1:0]      lim_short;
    logic [CMP_W-1:0]      lim_dot;
    logic [CMP_W-1:0]      lim_dash;
    logic                  is_end;
    logic                  is_dot;
    logic                  is_dash;

    assign fall = r_prev & ~i_key_level;
    assign rise = ~r_prev & i_key_level;
    assign inc  = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;

    assign len        = CMP_W'(inc);
    assign lim_glitch = CMP_W'(i_cfg.glitch_ms);
    assign lim_short  = CMP_W'(i_cfg.short_limit);
    assign lim_dot    = CMP_W'(i_cfg.dot_limit);
    assign lim_dash   = CMP_W'(i_cfg.dash_limit);

    assign is_end  = rise && (len > lim_glitch) && (len < lim_short);
    assign is_dot  = rise && !is_end && (len > lim_short) && (len < lim_dot);
    assign is_dash = rise && !is_end && !is_dot && (len > lim_dot) && (len < lim_dash);

    always_comb begin
        n_prev    = i_key_level;
        n_elapsed = fall ? '0 : inc;
        n_bits    = r_bits;
        n_count   = r_count;
        if (is_end) begin
            n_bits  = '0;
            n_count = '0;
        end else if (is_dot || is_dash) begin
            if (r_count < SYM_MAX) begin
                n_bits[r_count[1:0]] = is_dash;
                n_count              = r_count + 3'd1;
            end else begin
                n_count = SYM_OVERLONG;
            end
        end
    end

    always_comb begin
        o_res_valid        = is_end || is_dot || is_dash;
        o_res.event_res    = is_end ? EV_END : (is_dash ? EV_DASH : EV_DOT);
        o_res.letter       = '0;
        o_res.letter_valid = 1'b0;
        if (is_end && (r_count != 3'd0)) begin
            o_res.letter       = decode_letter(r_count, r_bits);
            o_res.letter_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= 1'b0;
            r_elapsed <= '0;
            r_bits    <= '0;
            r_count   <= '0;
        end else if (i_fire) begin
            r_prev    <= n_prev;
            r_elapsed <= n_elapsed;
            r_bits    <= n_bits;
            r_count   <= n_count;
        end
    end

    a_fall_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && fall |=> r_elapsed == '0)
        else $error("press timer not cleared after a falling edge");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && is_end |=> r_count == 3'd0 && r_bits == 4'd0)
        else $error("symbol store not cleared after a letter end");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SYM_OVERLONG)
        else $error("symbol count out of range");

    a_overlong_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_count == SYM_OVERLONG && !is_end |=> r_count == SYM_OVERLONG)
        else $error("overlong symbol store left the overlong state");
endmodule

// ----- hdl/morse_key_decoder.sv -----
// Morse key decoder top level. A key word is first taken into the input register; when the
// result register can take a word, the core decodes it and a resulting event word is registered there.
// Throughput: one key word per cycle while no result word is stalled. While a result word is stalled,
// the input register takes at most one more key word and then holds the input off.
// Reset (synchronous, active low) restores the default bounds and clears the
// edge detector, press timer and symbol store. Depends on mkd_pkg and the channels.
module morse_key_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mkd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mkd_pkg::CFG_W-1:0]     i_cfg_data,
    mkd_key_if.sink                       i_key,
    mkd_res_if.source                     o_res
);
    import mkd_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    logic    core_res_valid;

    logic    r_in_valid;
    logic    r_in_key;
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    logic    fire;
    logic    in_take;

    assign advance     = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && advance;
    assign i_key.ready = !r_in_valid || advance;
    assign in_take     = i_key.valid && i_key.ready;

    mkd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mkd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_key_level (r_in_key),
        .i_cfg       (cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_key <= i_key.key_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && core_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_res_valid) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.event_res    = r_out.event_res;
    assign o_res.letter       = r_out.letter;
    assign o_res.letter_valid = r_out.letter_valid;

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> r_out_valid)
        else $error("result word dropped while stalled");

    a_no_fire_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> !r_out_valid || o_res.ready)
        else $error("decode step taken while the result register is held");

    a_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid)
        else $error("key word lost in the input register");
endmodule
